// ===== hdl/sapa_pkg.sv =====
// Shared constants and types for the sticky address pool allocator.
// No dependencies; used by sapa_slot_mem and sticky_address_pool_allocator.
package sapa_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W      = 11;   // slot counts up to POOL_DEPTH
  localparam int HW_W       = 48;
  localparam int ADDR_W     = 32;
  localparam int STAT_W     = 3;

  localparam logic [STAT_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STAT_W-1:0] ST_STICKY  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FREED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_IGNORED = 3'd4;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic REG_FIRST_ADDR = 1'b0;
  localparam logic REG_POOL_COUNT = 1'b1;

  // write request into the slot stores
  typedef struct packed {
    logic             inuse_we;
    logic             inuse_wd;
    logic             hw_we;
    logic [HW_W-1:0]  hw_wd;
    logic [IDX_W-1:0] waddr;
  } slot_wr_t;

endpackage

// ===== hdl/sapa_slot_mem.sv =====
// Per-slot stores: in-use bit and remembered hardware address.
// One write and one registered read per cycle. Depends on sapa_pkg.
module sapa_slot_mem (
  input  logic                       clk,
  input  sapa_pkg::slot_wr_t         wr,
  input  logic [sapa_pkg::IDX_W-1:0] raddr,
  output logic                       inuse_q,
  output logic [sapa_pkg::HW_W-1:0]  hw_q
);
  import sapa_pkg::*;

  logic            inuse_mem [POOL_DEPTH];
  logic [HW_W-1:0] hw_mem    [POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.inuse_we) begin
      inuse_mem[wr.waddr] <= wr.inuse_wd;
    end
    if (wr.hw_we) begin
      hw_mem[wr.waddr] <= wr.hw_wd;
    end
    inuse_q <= inuse_mem[raddr];
    hw_q    <= hw_mem[raddr];
  end

endmodule

// ===== hdl/sticky_address_pool_allocator.sv =====
// Top level of the sticky address pool allocator: sequencer, registers, ports.
// Depends on sapa_pkg and sapa_slot_mem.
//
// Hands out addresses first_addr + slot from one pool of up to 1024 slots. Each word on the
// input stream is an allocate or a free; each gives exactly one result word. After reset the
// block sweeps both slot stores to zero, one slot per cycle, and holds s_tready low meanwhile;
// configuration writes are taken at any time. Items are handled one at a time by a sequencer
// around a single slot-store read port with registered read data. A free reads its slot,
// checks it and hands its result to the output register; an allocate on a full pool goes
// straight to that hand-off. Any other allocate walks the stores one slot per cycle: with a
// hardware address it first scans slots 0..n-1 for a free slot holding that address, then
// folds next_index below n, one subtract at a time (a single subtractor, only needed after
// pool_count was shrunk below next_index), then runs a next-fit scan from there, wrapping at
// n, n being the saturated pool count. The output register frees the input side while the
// result waits to be taken; if the previous result is still waiting, the hand-off cycle
// stalls until m_tready.
module sticky_address_pool_allocator (
  input  logic        clk,
  input  logic        rst,
  // config port: index 0 first_addr, 1 pool_count
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wr_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // action[0], has_hw_addr[1], hw_addr[49:2], free_addr[81:50]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // addr[31:0], status[34:32], used[45:35]
);
  import sapa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FREE_RD, S_FREE_CHK, S_STICKY, S_MOD, S_NEXTFIT, S_EMIT
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   clr_idx;
  logic [ADDR_W-1:0]  first_addr;
  logic [CNT_W-1:0]   pool_count;
  logic [CNT_W-1:0]   used_count;
  logic [IDX_W-1:0]   next_index;

  logic               req_has_hw;
  logic [HW_W-1:0]    req_hw;
  logic [ADDR_W-1:0]  off;
  logic [CNT_W-1:0]   scan_cnt;    // slots issued so far
  logic [IDX_W-1:0]   ptr;         // next-fit read pointer
  logic [CNT_W-1:0]   start;       // next_index folded below n
  logic               pend_v;      // a read is in flight
  logic [IDX_W-1:0]   pend_idx;

  logic [ADDR_W-1:0]  res_addr;
  logic [STAT_W-1:0]  res_status;
  logic [ADDR_W-1:0]  out_addr;
  logic [STAT_W-1:0]  out_status;
  logic [CNT_W-1:0]   out_used;

  logic [CNT_W-1:0]   n;
  logic               issue;
  logic               in_range;
  logic               sticky_hit;
  logic               free_hit;
  logic [IDX_W-1:0]   rd_addr;
  logic               inuse_q;
  logic [HW_W-1:0]    hw_q;
  slot_wr_t           wr;
  logic [IDX_W-1:0]   pend_succ;

  // input fields
  logic               in_action;
  logic               in_has_hw;
  logic [HW_W-1:0]    in_hw;
  logic [ADDR_W-1:0]  in_free_addr;

  assign in_action    = s_tdata[0];
  assign in_has_hw    = s_tdata[1];
  assign in_hw        = s_tdata[49:2];
  assign in_free_addr = s_tdata[81:50];

  assign n = (pool_count > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : pool_count;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {2'b00, out_used, out_status, out_addr};

  assign in_range   = off < ADDR_W'(n);
  assign issue      = ((state == S_STICKY) || (state == S_NEXTFIT)) && (scan_cnt < n);
  assign sticky_hit = pend_v && !inuse_q && (hw_q == req_hw);
  assign free_hit   = pend_v && !inuse_q;
  assign pend_succ  = ({1'b0, pend_idx} == n - CNT_W'(1)) ? '0 : pend_idx + IDX_W'(1);

  always_comb begin
    case (state)
      S_FREE_RD: rd_addr = off[IDX_W-1:0];
      S_STICKY:  rd_addr = scan_cnt[IDX_W-1:0];
      default:   rd_addr = ptr;
    endcase
  end

  always_comb begin
    wr = '0;
    case (state)
      S_CLEAR: begin
        wr.inuse_we = 1'b1;
        wr.hw_we    = 1'b1;
        wr.waddr    = clr_idx;
      end
      S_FREE_CHK: begin
        wr.inuse_we = in_range && inuse_q;
        wr.waddr    = off[IDX_W-1:0];
      end
      S_STICKY: begin
        wr.inuse_we = sticky_hit;
        wr.inuse_wd = 1'b1;
        wr.waddr    = pend_idx;
      end
      S_NEXTFIT: begin
        wr.inuse_we = free_hit;
        wr.inuse_wd = 1'b1;
        wr.hw_we    = free_hit && req_has_hw;
        wr.hw_wd    = req_hw;
        wr.waddr    = pend_idx;
      end
      default: wr = '0;
    endcase
  end

  sapa_slot_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .raddr   (rd_addr),
    .inuse_q (inuse_q),
    .hw_q    (hw_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      first_addr <= '0;
      pool_count <= CNT_W'(1024);
      used_count <= '0;
      next_index <= '0;
      pend_v     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_FIRST_ADDR) begin
          first_addr <= cfg_wr_data;
        end else begin
          pool_count <= cfg_wr_data[CNT_W-1:0];
        end
      end
      // S_EMIT drives m_tvalid itself
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if ({1'b0, clr_idx} == CNT_W'(POOL_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            req_has_hw <= in_has_hw;
            req_hw     <= in_hw;
            off        <= in_free_addr - first_addr;
            scan_cnt   <= '0;
            pend_v     <= 1'b0;
            if (in_action == ACT_FREE) begin
              state <= S_FREE_RD;
            end else if (n == '0 || used_count >= n) begin
              res_addr   <= '0;
              res_status <= ST_FULL;
              state      <= S_EMIT;
            end else if (in_has_hw) begin
              state <= S_STICKY;
            end else begin
              start <= {1'b0, next_index};
              state <= S_MOD;
            end
          end
        end
        S_FREE_RD: state <= S_FREE_CHK;
        S_FREE_CHK: begin
          res_addr <= '0;
          if (in_range && inuse_q) begin
            res_status <= ST_FREED;
            if (used_count != '0) begin
              used_count <= used_count - CNT_W'(1);
            end
          end else begin
            res_status <= ST_IGNORED;
          end
          state <= S_EMIT;
        end
        S_STICKY: begin
          if (sticky_hit) begin
            used_count <= used_count + CNT_W'(1);
            res_addr   <= first_addr + ADDR_W'(pend_idx);
            res_status <= ST_STICKY;
            state      <= S_EMIT;
          end else begin
            pend_v <= issue;
            if (issue) begin
              pend_idx <= scan_cnt[IDX_W-1:0];
              scan_cnt <= scan_cnt + CNT_W'(1);
            end else if (!pend_v) begin
              start <= {1'b0, next_index};
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          // fold next_index below a shrunk pool, one subtract per cycle
          if (start >= n) begin
            start <= start - n;
          end else begin
            ptr      <= start[IDX_W-1:0];
            scan_cnt <= '0;
            pend_v   <= 1'b0;
            state    <= S_NEXTFIT;
          end
        end
        S_NEXTFIT: begin
          if (free_hit) begin
            used_count <= used_count + CNT_W'(1);
            next_index <= pend_succ;
            res_addr   <= first_addr + ADDR_W'(pend_idx);
            res_status <= ST_NEW;
            state      <= S_EMIT;
          end else begin
            pend_v <= issue;
            if (issue) begin
              pend_idx <= ptr;
              ptr      <= ({1'b0, ptr} == n - CNT_W'(1)) ? '0 : ptr + IDX_W'(1);
              scan_cnt <= scan_cnt + CNT_W'(1);
            end else if (!pend_v) begin
              res_addr   <= '0;
              res_status <= ST_FULL;
              state      <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_addr   <= res_addr;
            out_status <= res_status;
            out_used   <= used_count;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- assertions ----
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(POOL_DEPTH))
    else $error("used count above pool depth");

  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_status == ST_FULL || out_status == ST_FREED || out_status == ST_IGNORED)
      |-> out_addr == '0)
    else $error("nonzero address on failed allocate or free");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while busy");

endmodule

// ===== tb/sticky_address_pool_allocator_test.sv =====
// Self-checking testbench for sticky_address_pool_allocator: directed and random
// allocate/free streams under random idling, checked word by word against a predictor.
// Depends on sapa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module sticky_address_pool_allocator_test;
  import sapa_pkg::*;

  localparam int WATCHDOG_LIMIT = 12000; // covers the reset sweep and the longest allocate scans
  localparam int HOLD_CYCLES    = 300;

  // fields from the lowest bit up: addr, status, used
  typedef struct packed {
    logic [CNT_W-1:0]  used;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr;
  } lease_t;

  // Lease bookkeeping: mirrors the allocator state and holds the results still owed.
  class lease_board;
    logic [ADDR_W-1:0] first_addr = '0;
    int                pool_count = 1024;
    bit                in_use[POOL_DEPTH];
    bit [HW_W-1:0]     hw_mem[POOL_DEPTH];
    int                used_cnt = 0;
    int                next_slot = 0;
    lease_t            owed_q[$];
    int                errors = 0;

    function int slots();
      return (pool_count > POOL_DEPTH) ? POOL_DEPTH : pool_count;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == REG_FIRST_ADDR) first_addr = data;
      else pool_count = data[CNT_W-1:0];
    endfunction

    // note an accepted word and queue the lease result it must produce
    function void note_word(logic act, logic has_hw, logic [HW_W-1:0] hw,
                            logic [ADDR_W-1:0] free_addr);
      int n;
      int slot;
      logic [ADDR_W-1:0] off;
      lease_t r;
      n = slots();
      r.addr = '0;
      r.status = ST_FULL;
      if (act == ACT_FREE) begin
        off = free_addr - first_addr;
        r.status = ST_IGNORED;
        if (off < n && in_use[off]) begin
          in_use[off] = 0;
          if (used_cnt > 0) used_cnt--;
          r.status = ST_FREED;
        end
      end else if (n != 0 && used_cnt < n) begin
        // sticky match first: lowest free slot remembering this hw address
        if (has_hw) begin
          for (int i = 0; i < n; i++) begin
            if (hw_mem[i] == hw && !in_use[i]) begin
              in_use[i] = 1;
              used_cnt++;
              r.addr = first_addr + i;
              r.status = ST_STICKY;
              break;
            end
          end
        end
        if (r.status == ST_FULL) begin
          for (int i = 0; i < n; i++) begin
            slot = (next_slot + i) % n;
            if (!in_use[slot]) begin
              in_use[slot] = 1;
              used_cnt++;
              next_slot = (slot + 1) % n;
              if (has_hw) hw_mem[slot] = hw;
              r.addr = first_addr + slot;
              r.status = ST_NEW;
              break;
            end
          end
        end
      end
      r.used = used_cnt[CNT_W-1:0];
      owed_q.push_back(r);
    endfunction

    function void check_word(lease_t got);
      lease_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.addr !== want.addr) begin
        $display("%0t: addr expected %h actual %h", $realtime, want.addr, got.addr);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
        errors++;
      end
      if (got.used !== want.used) begin
        $display("%0t: used expected %0d actual %0d", $realtime, want.used, got.used);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wr_en = 0;
  logic        cfg_index = 0;
  logic [31:0] cfg_wr_data = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;   // action, has_hw_addr, hw_addr, free_addr, zero pad
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [47:0] m_tdata;        // addr, status, used, zero pad

  lease_board board;
  bit         no_idle = 0;     // suppresses random idling on both sides
  bit         hold_req = 0;    // asks the receiver for a long hold-off
  int         quiet_cycles = 0;
  logic [HW_W-1:0] hw_set[6];  // small set of client addresses so sticky hits happen

  always #5 clk = ~clk;

  sticky_address_pool_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Receiver: random back-pressure, plus one long hold-off counted here on request.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold == 0) begin
        hold = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        m_tready = 0;
      end else begin
        m_tready = no_idle || ($urandom_range(99) >= 38);
      end
    end
  end

  // Result monitor, sampled on the rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata[45:0]);
  end

  // Watchdog: counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic cfg_write(logic idx, logic [31:0] data);
    @(negedge clk);
    cfg_wr_en = 1;
    cfg_index = idx;
    cfg_wr_data = data;
    @(negedge clk);
    cfg_wr_en = 0;
    board.write_reg(idx, data);
  endtask

  // drive one word from the falling edge, hold until accepted, then maybe idle
  task automatic put_word(logic act, logic has_hw, logic [HW_W-1:0] hw,
                          logic [ADDR_W-1:0] free_addr);
    @(negedge clk);
    s_tvalid = 1;
    s_tdata = {6'b0, free_addr, hw, has_hw, act};
    do @(posedge clk); while (!s_tready);
    board.note_word(act, has_hw, hw, free_addr);
    @(negedge clk);
    s_tvalid = 0;
    while (!no_idle && $urandom_range(99) < 38) @(negedge clk);
  endtask

  // sender pause: nothing goes in until every owed word has come back
  task automatic drain();
    while (board.owed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(logic [31:0] first, logic [31:0] count, int items);
    int n;
    logic act;
    logic has_hw;
    logic [HW_W-1:0] hw;
    logic [ADDR_W-1:0] fa;
    drain();
    cfg_write(REG_FIRST_ADDR, first);
    cfg_write(REG_POOL_COUNT, count);
    n = board.slots();
    for (int k = 0; k < items; k++) begin
      // lean toward frees when the pool is full so allocates keep succeeding
      if (board.used_cnt >= n) act = ($urandom_range(99) < 70) ? ACT_FREE : ACT_ALLOC;
      else act = ($urandom_range(99) < 40) ? ACT_FREE : ACT_ALLOC;
      has_hw = ($urandom_range(99) < 70);
      hw = ($urandom_range(3) == 0) ? HW_W'({$urandom, $urandom}) : hw_set[$urandom_range(5)];
      case ($urandom_range(9))
        0: fa = $urandom;
        1: fa = first + n;          // just past the pool
        default: fa = first + $urandom_range((n > 0) ? n - 1 : 0);
      endcase
      put_word(act, has_hw, hw, fa);
      if (k == items / 2 && $urandom_range(1) == 0) drain();
    end
  endtask

  initial begin
    board = new;
    hw_set[0] = '0;
    hw_set[1] = '1;
    hw_set[2] = 48'h0200_5E00_0001;
    hw_set[3] = 48'hA5A5_5A5A_A5A5;
    hw_set[4] = HW_W'({$urandom, $urandom});
    hw_set[5] = HW_W'({$urandom, $urandom});
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: four slots straddling the top of the address space.
    cfg_write(REG_FIRST_ADDR, 32'hFFFF_FFFE);
    cfg_write(REG_POOL_COUNT, 32'd4);
    put_word(ACT_ALLOC, 1, '0, '0);            // zero hw matches a never-written slot
    put_word(ACT_ALLOC, 1, '1, '1);            // new slot, all-ones hw recorded
    put_word(ACT_ALLOC, 0, '1, '0);            // wraps to address 0
    put_word(ACT_ALLOC, 1, 48'h1234, '0);
    put_word(ACT_ALLOC, 1, 48'h1234, '0);      // pool full
    put_word(ACT_FREE, 0, '0, 32'hFFFF_FFFF);  // freed
    put_word(ACT_FREE, 0, '0, 32'hFFFF_FFFF);  // already free: ignored
    put_word(ACT_FREE, 1, '1, 32'd2);          // out of range: ignored
    put_word(ACT_ALLOC, 1, '1, '0);            // sticky reuse of the all-ones slot
    put_word(ACT_FREE, 0, '0, 32'd0);
    put_word(ACT_FREE, 1, '1, 32'hFFFF_FFFE);
    put_word(ACT_ALLOC, 0, '0, '1);            // next-fit
    put_word(ACT_ALLOC, 1, 48'h1234, '0);      // no sticky hit: the slot it wrote is still in use, so next-fit
    put_word(ACT_FREE, 0, '0, 32'd1);
    put_word(ACT_FREE, 0, '0, 32'hFFFF_FFFD);  // just below the pool

    // Random phases; state carries across, so shrinks leave slots stranded.
    random_phase(32'h0A00_0000, 16, 350);
    random_phase(32'h0000_0000, 1, 120);
    hold_req = 1;                              // receiver stalls while we keep sending
    random_phase(32'hFFFF_FFF0, 64, 400);
    random_phase($urandom, 0, 50);             // always full, every free ignored
    random_phase($urandom, 8, 350);            // shrunk with slots in use
    no_idle = 1;
    random_phase(32'h0000_1000, 2047, 25);     // saturates at the full depth
    no_idle = 0;
    random_phase(32'hFFFF_FFFF, 1024, 25);
    random_phase($urandom, 32, 650);

    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.owed_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
